>>> src/simm_pkg.sv
// ----------------------------------------------------------------------------
// simm_pkg
// Shared types and constants for the square integer matrix multiplier.
// ----------------------------------------------------------------------------
package simm_pkg;

  localparam int DATA_W = 32;  // element and product word
  localparam int IDX_W  = 6;   // row / column index on the ports
  localparam int DIM_W  = 7;   // matrix_dim register

  typedef enum logic [1:0] {
    OP_WRITE_A  = 2'd0,
    OP_WRITE_B  = 2'd1,
    OP_MULTIPLY = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  // write port of one matrix store
  typedef struct packed {
    logic              we;
    logic [DATA_W-1:0] data;
  } wr_ctl_t;

endpackage

>>> src/square_integer_matrix_multiply.sv
// ----------------------------------------------------------------------------
// square_integer_matrix_multiply
// C = A * B over the leading matrix_dim corner, 32-bit wrapping arithmetic.
//
//  channel  handshake                  payload
//  -------  -------------------------  ------------------------------------
//  input    start && !busy             in_operation, in_row_index,
//                                      in_col_index, in_element_value
//  result   out_valid (one cycle)      out_product_value, out_row, out_col
//  config   cfg_valid && cfg_ready     cfg_matrix_dim
//
// A read returns its result on the cycle after the transaction, and reads may
// follow each other every cycle while busy is low.
// A multiply keeps busy high until its final C entry is written; the single
// read port of each operand RAM sets its pace at one MAC per cycle.
// cfg_ready is low while busy and while start is high.
// Reset: synchronous, active low; matrix_dim returns to 64, RAM contents are
// left as they are. The result side is never stalled.
// ----------------------------------------------------------------------------
module square_integer_matrix_multiply
  import simm_pkg::*;
#(
  parameter int MAX_DIM = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_operation,
  input  logic [IDX_W-1:0]         in_row_index,
  input  logic [IDX_W-1:0]         in_col_index,
  input  logic signed [DATA_W-1:0] in_element_value,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_product_value,
  output logic [IDX_W-1:0]         out_row,
  output logic [IDX_W-1:0]         out_col,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [DIM_W-1:0]         cfg_matrix_dim
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int CNT_W  = $clog2(MAX_DIM);
  localparam int ADDR_W = $clog2(DEPTH);

  logic [DIM_W-1:0]  matrix_dim_r;
  logic [CNT_W-1:0]  last;
  logic              accept;
  op_t               op;
  logic              in_store, in_dim;
  logic [ADDR_W-1:0] host_addr;
  wr_ctl_t           a_wr, b_wr, c_wr;
  logic [ADDR_W-1:0] a_raddr, b_raddr, c_waddr;
  logic [DATA_W-1:0] a_rdata, b_rdata, c_rdata;
  logic              eng_busy;
  logic              rd_v_r, rd_in_r;
  logic [IDX_W-1:0]  rd_row_r, rd_col_r;

  assign op     = op_t'(in_operation);
  assign busy   = eng_busy;
  assign accept = start && !eng_busy;

  // never take a new dimension in the same cycle as an input transaction
  assign cfg_ready = !eng_busy && !start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_dim_r <= DIM_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      matrix_dim_r <= cfg_matrix_dim;
    end
  end

  // last valid index of the active corner, dimension clamped to 1..MAX_DIM
  always_comb begin
    if (matrix_dim_r == '0) begin
      last = '0;
    end else if (32'(matrix_dim_r) > MAX_DIM) begin
      last = CNT_W'(MAX_DIM - 1);
    end else begin
      last = CNT_W'(matrix_dim_r - DIM_W'(1));
    end
  end

  assign in_store  = (32'(in_row_index) < MAX_DIM) && (32'(in_col_index) < MAX_DIM);
  assign in_dim    = (32'(in_row_index) <= 32'(last)) && (32'(in_col_index) <= 32'(last));
  assign host_addr = ADDR_W'(32'(in_row_index) * MAX_DIM + 32'(in_col_index));

  assign a_wr.we   = accept && (op == OP_WRITE_A) && in_store;
  assign a_wr.data = in_element_value;
  assign b_wr.we   = accept && (op == OP_WRITE_B) && in_store;
  assign b_wr.data = in_element_value;

  simm_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_mem_a (
    .clk   (clk),
    .wr    (a_wr),
    .waddr (host_addr),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  simm_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_mem_b (
    .clk   (clk),
    .wr    (b_wr),
    .waddr (host_addr),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  simm_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_mem_c (
    .clk   (clk),
    .wr    (c_wr),
    .waddr (c_waddr),
    .raddr (host_addr),
    .rdata (c_rdata)
  );

  simm_engine #(.MAX_DIM(MAX_DIM), .CNT_W(CNT_W), .ADDR_W(ADDR_W)) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (accept && (op == OP_MULTIPLY)),
    .last    (last),
    .a_raddr (a_raddr),
    .b_raddr (b_raddr),
    .a_rdata (a_rdata),
    .b_rdata (b_rdata),
    .c_wr    (c_wr),
    .c_waddr (c_waddr),
    .busy    (eng_busy)
  );

  // read transaction: C data arrives in the following cycle from the registered C read port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= accept && (op == OP_READ);
    end
  end

  always_ff @(posedge clk) begin
    rd_in_r  <= in_dim;
    rd_row_r <= in_row_index;
    rd_col_r <= in_col_index;
  end

  assign out_valid         = rd_v_r;
  assign out_product_value = rd_in_r ? c_rdata : '0;
  assign out_row           = rd_row_r;
  assign out_col           = rd_col_r;

  // a result only follows an accepted read
  a_out_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_operation == OP_READ))
    else $error("result without a read transaction");

  // C is written only by a running multiply
  a_c_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    c_wr.we |-> eng_busy)
    else $error("C write while idle");

  // multiply command makes the block busy
  a_mult_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == OP_MULTIPLY) |=> busy)
    else $error("multiply accepted but block not busy");

  // a multiply ends on its final C write
  a_end_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> $past(c_wr.we))
    else $error("multiply finished without final write");

endmodule

>>> src/simm_mem.sv
// ----------------------------------------------------------------------------
// simm_mem
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module simm_mem
  import simm_pkg::*;
#(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  wr_ctl_t           wr,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[waddr] <= wr.data;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/simm_engine.sv
// ----------------------------------------------------------------------------
// simm_engine
// Multiply sequencer: walks i, j, k over the active corner, reads A and B,
// multiplies, accumulates and writes each finished C entry back.
// ----------------------------------------------------------------------------
module simm_engine
  import simm_pkg::*;
#(
  parameter int MAX_DIM = 64,
  parameter int CNT_W   = 6,
  parameter int ADDR_W  = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [CNT_W-1:0]  last,
  output logic [ADDR_W-1:0] a_raddr,
  output logic [ADDR_W-1:0] b_raddr,
  input  logic [DATA_W-1:0] a_rdata,
  input  logic [DATA_W-1:0] b_rdata,
  output wr_ctl_t           c_wr,
  output logic [ADDR_W-1:0] c_waddr,
  output logic              busy
);

  logic              run_r, run_nxt;
  logic [CNT_W-1:0]  i_r, j_r, k_r;
  logic              v1_r, v2_r;
  logic [CNT_W-1:0]  i1_r, j1_r, i2_r, j2_r;
  logic              kf1_r, kl1_r, kf2_r, kl2_r;
  logic [DATA_W-1:0] prod_r, acc_r, acc_nxt;
  logic              k_end, j_end, i_end;

  assign k_end = (k_r == last);
  assign j_end = (j_r == last);
  assign i_end = (i_r == last);

  always_comb begin
    run_nxt = run_r;
    if (go) begin
      run_nxt = 1'b1;
    end else if (run_r && k_end && j_end && i_end) begin
      run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
    end else begin
      run_r <= run_nxt;
      v1_r  <= run_r;
      v2_r  <= v1_r;
    end
  end

  // loop counters, k innermost
  always_ff @(posedge clk) begin
    if (go) begin
      i_r <= '0;
      j_r <= '0;
      k_r <= '0;
    end else if (run_r) begin
      if (k_end) begin
        k_r <= '0;
        if (j_end) begin
          j_r <= '0;
          i_r <= i_r + CNT_W'(1);
        end else begin
          j_r <= j_r + CNT_W'(1);
        end
      end else begin
        k_r <= k_r + CNT_W'(1);
      end
    end
  end

  // pipeline tags and datapath
  always_ff @(posedge clk) begin
    i1_r   <= i_r;
    j1_r   <= j_r;
    kf1_r  <= (k_r == '0);
    kl1_r  <= k_end;
    i2_r   <= i1_r;
    j2_r   <= j1_r;
    kf2_r  <= kf1_r;
    kl2_r  <= kl1_r;
    prod_r <= DATA_W'(a_rdata * b_rdata);  // low word, wraps
    if (v2_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc_nxt = (kf2_r ? '0 : acc_r) + prod_r;

  assign a_raddr = ADDR_W'(32'(i_r) * MAX_DIM + 32'(k_r));
  assign b_raddr = ADDR_W'(32'(k_r) * MAX_DIM + 32'(j_r));
  assign c_waddr = ADDR_W'(32'(i2_r) * MAX_DIM + 32'(j2_r));

  assign c_wr.we   = v2_r && kl2_r;
  assign c_wr.data = acc_nxt;

  assign busy = run_r || v1_r || v2_r;

endmodule
